>>> hdl/trd_pkg.sv
package trd_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    REG_RLE_MODE  = 2'd0,
    REG_BPP       = 2'd1,
    REG_PIX_TOTAL = 2'd2
  } trd_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EARLY_END = 2'd2
  } trd_status_t;

  typedef struct packed {
    logic        rle_mode;
    logic [2:0]  bpp;
    logic [31:0] pixel_total;
  } trd_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  rep;
    trd_status_t status;
    logic        done;
  } trd_res_t;

endpackage

>>> hdl/trd_cfg.sv
module trd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [trd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [trd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [trd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output trd_pkg::trd_cfg_t               cfg
);
  import trd_pkg::*;

  trd_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = trd_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rle_mode    <= 1'b1;
      cfg.bpp         <= 3'd4;
      cfg.pixel_total <= 32'd1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RLE_MODE:  cfg.rle_mode    <= pwdata[0];
        REG_BPP:       cfg.bpp         <= pwdata[2:0];
        REG_PIX_TOTAL: cfg.pixel_total <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RLE_MODE:  prdata = {31'd0, cfg.rle_mode};
      REG_BPP:       prdata = {29'd0, cfg.bpp};
      REG_PIX_TOTAL: prdata = cfg.pixel_total;
      default:       prdata = '0;
    endcase
  end

endmodule

>>> hdl/trd_dec.sv
module trd_dec (
  input  logic              clk,
  input  logic              rst,
  input  trd_pkg::trd_cfg_t cfg,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output trd_pkg::trd_res_t res
);
  import trd_pkg::*;

  logic        expect_header, expect_header_next;
  logic        run_packet, run_packet_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] pixel_bytes, pixel_bytes_next;
  logic [31:0] pixels_done, pixels_done_next;
  logic        halted, halted_next;

  logic [2:0]  bpp_eff;
  logic [7:0]  count;
  logic [32:0] run_end;
  logic [31:0] merged;
  logic        complete;
  logic [7:0]  rep;
  logic [7:0]  r5, g5, b5;

  always_comb begin
    if (cfg.bpp inside {3'd0, 3'd1, 3'd2}) bpp_eff = 3'd2;
    else if (cfg.bpp == 3'd3)              bpp_eff = 3'd3;
    else                                   bpp_eff = 3'd4;
  end

  assign count    = {1'b0, data_byte[6:0]} + 8'd1;
  assign run_end  = {1'b0, pixels_done} + {25'd0, count};
  assign complete = ({1'b0, byte_index} + 3'd1) >= bpp_eff;

  always_comb begin
    case (byte_index)
      2'd0:    merged = pixel_bytes | {24'd0, data_byte};
      2'd1:    merged = pixel_bytes | {16'd0, data_byte, 8'd0};
      2'd2:    merged = pixel_bytes | {8'd0, data_byte, 16'd0};
      default: merged = pixel_bytes | {data_byte, 24'd0};
    endcase
  end

  assign r5 = {merged[14:10], merged[14:12]};
  assign g5 = {merged[9:5], merged[9:7]};
  assign b5 = {merged[4:0], merged[4:2]};

  always_comb begin
    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    packet_left_next   = packet_left;
    byte_index_next    = byte_index;
    pixel_bytes_next   = pixel_bytes;
    pixels_done_next   = pixels_done;
    halted_next        = halted;
    rep                = 8'd1;
    res                = '0;
    res.status         = ST_OK;

    if (accept && !halted) begin
      if (pixels_done >= cfg.pixel_total) begin
        halted_next = 1'b1;
        res.valid   = 1'b1;
        res.done    = 1'b1;
      end else if (cfg.rle_mode && expect_header) begin
        if (last_byte) begin
          halted_next = 1'b1;
          res.valid   = 1'b1;
          res.status  = ST_EARLY_END;
          res.done    = 1'b1;
        end else if (run_end > {1'b0, cfg.pixel_total}) begin
          halted_next = 1'b1;
          res.valid   = 1'b1;
          res.status  = ST_OVERFLOW;
          res.done    = 1'b1;
        end else begin
          run_packet_next    = data_byte[7];
          packet_left_next   = count;
          expect_header_next = 1'b0;
          byte_index_next    = 2'd0;
          pixel_bytes_next   = '0;
        end
      end else if (!complete) begin
        byte_index_next  = byte_index + 2'd1;
        pixel_bytes_next = merged;
        if (last_byte) begin
          halted_next = 1'b1;
          res.valid   = 1'b1;
          res.status  = ST_EARLY_END;
          res.done    = 1'b1;
        end
      end else begin
        if (cfg.rle_mode) begin
          if (run_packet) begin
            rep              = packet_left;
            packet_left_next = 8'd0;
          end else begin
            packet_left_next = packet_left - 8'd1;
          end
          if (packet_left_next == 8'd0) expect_header_next = 1'b1;
        end
        pixels_done_next = pixels_done + {24'd0, rep};
        byte_index_next  = 2'd0;
        pixel_bytes_next = '0;
        res.valid = 1'b1;
        res.rep   = rep;
        if (bpp_eff == 3'd2) begin
          res.red   = r5;
          res.green = g5;
          res.blue  = b5;
          res.alpha = 8'hFF;
        end else begin
          res.blue  = merged[7:0];
          res.green = merged[15:8];
          res.red   = merged[23:16];
          res.alpha = (bpp_eff == 3'd4) ? merged[31:24] : 8'hFF;
        end
        if (pixels_done_next >= cfg.pixel_total) begin
          halted_next = 1'b1;
          res.done    = 1'b1;
        end else if (last_byte) begin
          halted_next = 1'b1;
          res.status  = ST_EARLY_END;
          res.done    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      packet_left   <= '0;
      byte_index    <= '0;
      pixel_bytes   <= '0;
      pixels_done   <= '0;
      halted        <= 1'b0;
    end else begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      packet_left   <= packet_left_next;
      byte_index    <= byte_index_next;
      pixel_bytes   <= pixel_bytes_next;
      pixels_done   <= pixels_done_next;
      halted        <= halted_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt flag cleared without reset");

  a_done_halts: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done |=> halted) else $error("image end did not halt");

  a_no_result_halted: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res.valid) else $error("result after image end");

  a_error_blank: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |-> res.done)
    else $error("error result without image end");

endmodule

>>> hdl/trd_out.sv
module trd_out (
  input  logic                            clk,
  input  logic                            rst,
  input  trd_pkg::trd_res_t               res,
  input  logic                            accept,
  output logic                            in_ready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [trd_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [trd_pkg::OUT_USER_W-1:0]  m_tuser,
  output logic                            m_tlast
);
  import trd_pkg::*;

  logic [OUT_DATA_W-1:0] data;
  logic [OUT_USER_W-1:0] user;
  logic                  last;

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      data <= {res.rep, res.alpha, res.blue, res.green, res.red};
      user <= res.status;
      last <= res.done;
    end
  end

  assign m_tdata = data;
  assign m_tuser = user;
  assign m_tlast = last;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(data) && $stable(last))
    else $error("pending result lost");

  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    accept |-> in_ready) else $error("transaction taken while stalled");

endmodule

>>> hdl/tga_rle_pixel_decoder.sv
// Channel  Dir  Payload
// s_       in   tdata[7:0] data_byte, tlast last_byte
// m_       out  tdata red, green, blue, alpha, repeat_res; tuser status; tlast image_done
// apb      in   0x0 rle_mode, 0x4 bytes_per_pixel, 0x8 pixel_total
//
// One byte per clock while s_tready is high; a result appears in the output register the cycle after its byte.
// Decode state and the output register update in the same cycle as the transaction.
// s_tready is low only while a result waits in the output register and m_tready is low.
// Reset clears decode state and sets registers to rle 1, 4 bytes per pixel, total 1.
// After image_done, bytes are taken and dropped until reset.
module tga_rle_pixel_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [trd_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [trd_pkg::OUT_DATA_W-1:0]  m_tdata,   // red, green, blue, alpha, repeat_res
  output logic [trd_pkg::OUT_USER_W-1:0]  m_tuser,   // [1:0] status
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [trd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [trd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [trd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import trd_pkg::*;

  trd_cfg_t cfg;
  trd_res_t res;
  logic     accept;

  assign accept = s_tvalid && s_tready;

  trd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trd_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .res       (res)
  );

  trd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .accept   (accept),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> test/testbench.sv
module testbench;
  import trd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned STALL_CYCLES = 240;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_byte_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  rep;
    trd_status_t status;
    logic        done;
  } pixel_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // decoder copy: configuration and decode state
  logic        cfg_rle;
  logic [2:0]  cfg_bpp;
  logic [31:0] cfg_total;
  logic        pend_header;
  logic        run_pkt;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_idx;
  logic [31:0] pix_word;
  logic [31:0] pix_count;
  logic        dec_halted;

  in_byte_t    pending_bytes[$];
  pixel_res_t  expected_pixels[$];
  in_byte_t    next_byte;
  int          src_wait = 0;
  int          sink_wait = 0;
  logic        src_quiet = 1'b0;
  logic        sink_quiet = 1'b0;
  logic        stall_kick = 1'b0;
  int unsigned stall_left = 0;
  int unsigned queued_total = 0;
  int          fail_count = 0;

  tga_rle_pixel_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat
    .m_tuser  (m_tuser),   // [1:0] status
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned eff_bpp();
    if (cfg_bpp < 3'd2) return 2;
    if (cfg_bpp > 3'd4) return 4;
    return cfg_bpp;
  endfunction

  function automatic int draw_gap(input logic quiet);
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic pixel_res_t make_pixel(input logic [31:0] word, input logic [7:0] rep,
                                            input trd_status_t st, input logic done,
                                            input logic has_pixel);
    pixel_res_t r;
    r.red = 8'd0;
    r.green = 8'd0;
    r.blue = 8'd0;
    r.alpha = 8'd0;
    r.rep = rep;
    r.status = st;
    r.done = done;
    if (has_pixel) begin
      if (eff_bpp() == 2) begin
        r.red = {word[14:10], word[14:12]};
        r.green = {word[9:5], word[9:7]};
        r.blue = {word[4:0], word[4:2]};
        r.alpha = 8'hFF;
      end else begin
        r.blue = word[7:0];
        r.green = word[15:8];
        r.red = word[23:16];
        r.alpha = (eff_bpp() == 4) ? word[31:24] : 8'hFF;
      end
    end
    return r;
  endfunction

  function automatic void reset_decoder();
    cfg_rle = 1'b1;
    cfg_bpp = 3'd4;
    cfg_total = 32'd1;
    pend_header = 1'b1;
    run_pkt = 1'b0;
    pkt_left = 8'd0;
    byte_idx = 2'd0;
    pix_word = 32'd0;
    pix_count = 32'd0;
    dec_halted = 1'b0;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    int unsigned count;
    int unsigned rep;
    logic [31:0] word;
    if (dec_halted) return;
    if (pix_count >= cfg_total) begin
      dec_halted = 1'b1;
      expected_pixels.push_back(make_pixel(32'd0, 8'd0, ST_OK, 1'b1, 1'b0));
      return;
    end
    if (cfg_rle && pend_header) begin
      count = b[6:0] + 1;
      if (last) begin
        dec_halted = 1'b1;
        expected_pixels.push_back(make_pixel(32'd0, 8'd0, ST_EARLY_END, 1'b1, 1'b0));
      end else if ({1'b0, pix_count} + 33'(count) > {1'b0, cfg_total}) begin
        dec_halted = 1'b1;
        expected_pixels.push_back(make_pixel(32'd0, 8'd0, ST_OVERFLOW, 1'b1, 1'b0));
      end else begin
        run_pkt = b[7];
        pkt_left = 8'(count);
        pend_header = 1'b0;
        byte_idx = 2'd0;
        pix_word = 32'd0;
      end
      return;
    end
    pix_word = pix_word | (32'(b) << (8 * byte_idx));
    if (int'(byte_idx) + 1 < eff_bpp()) begin
      byte_idx = byte_idx + 2'd1;
      if (last) begin
        dec_halted = 1'b1;
        expected_pixels.push_back(make_pixel(32'd0, 8'd0, ST_EARLY_END, 1'b1, 1'b0));
      end
      return;
    end
    rep = 1;
    if (cfg_rle) begin
      if (run_pkt) begin
        rep = pkt_left;
        pkt_left = 8'd0;
      end else begin
        pkt_left = pkt_left - 8'd1;
      end
      if (pkt_left == 8'd0) pend_header = 1'b1;
    end
    pix_count = pix_count + rep;
    word = pix_word;
    byte_idx = 2'd0;
    pix_word = 32'd0;
    if (pix_count >= cfg_total) begin
      dec_halted = 1'b1;
      expected_pixels.push_back(make_pixel(word, 8'(rep), ST_OK, 1'b1, 1'b1));
    end else if (last) begin
      dec_halted = 1'b1;
      expected_pixels.push_back(make_pixel(word, 8'(rep), ST_EARLY_END, 1'b1, 1'b1));
    end else begin
      expected_pixels.push_back(make_pixel(word, 8'(rep), ST_OK, 1'b0, 1'b1));
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          s_tdata <= next_byte.data;
          s_tlast <= next_byte.last;
          s_tvalid <= 1'b1;
          src_wait <= draw_gap(src_quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_kick) begin
      stall_left <= STALL_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin : sink
    pixel_res_t want;
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("result transaction with no expected pixel pending");
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, m_tdata[7:0]);
        check_field("green", want.green, m_tdata[15:8]);
        check_field("blue", want.blue, m_tdata[23:16]);
        check_field("alpha", want.alpha, m_tdata[31:24]);
        check_field("repeat_res", want.rep, m_tdata[39:32]);
        check_field("status", want.status, m_tuser);
        check_field("image_done", want.done, m_tlast);
      end
      gap = draw_gap(sink_quiet);
      sink_wait <= gap;
      m_tready <= (gap == 0) && (stall_left == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (stall_left == 0);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RLE_MODE:  cfg_rle = value[0];
      REG_BPP:       cfg_bpp = value[2:0];
      REG_PIX_TOTAL: cfg_total = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    in_byte_t item;
    item.data = data;
    item.last = last;
    pending_bytes.push_back(item);
    queued_total++;
  endtask

  task automatic push_pixel(input logic end_last);
    int unsigned n;
    n = eff_bpp();
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), end_last && (i == n - 1));
  endtask

  task automatic push_packet();
    int unsigned count;
    logic run;
    if (!cfg_rle) begin
      push_pixel(1'b0);
      return;
    end
    run = $urandom_range(0, 1);
    if (run) count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
    else count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
    push_byte({run, 7'(count - 1)}, 1'b0);
    if (run) push_pixel(1'b0);
    else repeat (count) push_pixel(1'b0);
  endtask

  function automatic logic [31:0] big_total();
    case ($urandom_range(0, 2))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd4294836225;
      default: return pix_count + 32'd200000 + $urandom_range(0, 1000000);
    endcase
  endfunction

  initial begin
    int unsigned stop_at;
    int unsigned phase;
    int unsigned n;
    int unsigned ending;
    reset_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme bytes and counts, run and raw packets, all pixel sizes
    cfg_write(REG_UNUSED, $urandom());
    cfg_write(REG_PIX_TOTAL, 32'd1);
    cfg_write(REG_PIX_TOTAL, 32'hFFFF_FFFF);
    src_quiet = 1'b1;
    sink_quiet = 1'b1;
    push_byte(8'h80, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b0);
    wait_idle();
    cfg_write(REG_BPP, 32'd2);
    push_byte(8'h81, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    wait_idle();
    cfg_write(REG_RLE_MODE, 32'd0);
    cfg_write(REG_BPP, 32'd3);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hF0, 1'b0);
    wait_idle();

    stop_at = queued_total + RANDOM_BYTES;
    phase = 0;
    while (queued_total < stop_at) begin
      if (phase == 2) begin
        // hold the sink while the source streams back to back
        cfg_write(REG_RLE_MODE, 32'd0);
        cfg_write(REG_BPP, 32'd2);
        src_quiet = 1'b1;
        sink_quiet = 1'b0;
        @(posedge clk);
        stall_kick <= 1'b1;
        @(posedge clk);
        stall_kick <= 1'b0;
        repeat (80) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        cfg_write(REG_RLE_MODE, ($urandom() & ~32'h1) | $urandom_range(0, 1));
        cfg_write(REG_BPP, ($urandom() & ~32'h7) | $urandom_range(0, 7));
        cfg_write(REG_PIX_TOTAL, big_total());
        src_quiet = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
        n = queued_total + $urandom_range(15, 45);
        while (queued_total < n) push_packet();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      wait_idle();
      phase++;
    end

    // end the image one way, then feed bytes that must be dropped
    ending = $urandom_range(0, 5);
    src_quiet = ($urandom_range(0, 1) == 0);
    sink_quiet = ($urandom_range(0, 1) == 0);
    cfg_write(REG_RLE_MODE, (ending == 1 || ending == 2) ? 32'd1 : $urandom_range(0, 1));
    cfg_write(REG_BPP, $urandom_range(0, 7));
    cfg_write(REG_PIX_TOTAL, 32'hFFFF_FFFF);
    while (cfg_rle ? !pend_header : (byte_idx != 2'd0)) begin
      push_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_idle();
    end
    case (ending)
      0: begin
        n = $urandom_range(1, 3);
        cfg_write(REG_PIX_TOTAL, pix_count + n);
        if (cfg_rle) begin
          push_byte({1'b1, 7'(n - 1)}, 1'b0);
          push_pixel(1'b0);
        end else begin
          repeat (n) push_pixel(1'b0);
        end
      end
      1: push_byte(8'($urandom_range(0, 255)), 1'b1);
      2: begin
        n = $urandom_range(1, 127);
        cfg_write(REG_PIX_TOTAL, pix_count + n);
        push_byte({1'($urandom_range(0, 1)), 7'(n + $urandom_range(0, 127 - n))}, 1'b0);
      end
      3: begin
        if (cfg_rle) push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(0, 7))}, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      4: begin
        if (cfg_rle) push_byte({1'($urandom_range(0, 1)), 7'($urandom_range(0, 7))}, 1'b0);
        push_pixel(1'b1);
      end
      default: begin
        cfg_write(REG_PIX_TOTAL, ($urandom_range(0, 1) == 0) ? 32'd0 : pix_count);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    wait_idle();
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/trd_pkg.sv
hdl/trd_cfg.sv
hdl/trd_dec.sv
hdl/trd_out.sv
hdl/tga_rle_pixel_decoder.sv
test/testbench.sv
